>>> rtl/cv5_pkg.sv
`default_nettype none
package cv5_pkg;

  // window geometry
  localparam int WIN      = 5;
  localparam int PIX_W    = 8;
  localparam int COEF_W   = 8;
  localparam int MIN_SIZE = 5;

  // register port
  localparam int CFG_SIZE_W  = 13;
  localparam int CFG_DATA_W  = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int SIZE_W      = 14;  // holds any clamped size up to 8192

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CFG_DATA_W-1:0] RST_COEF_ROW     = 40'h01_0101_0101;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COEF_ROW_0   = 3'd2,
    CFG_COEF_ROW_1   = 3'd3,
    CFG_COEF_ROW_2   = 3'd4,
    CFG_COEF_ROW_3   = 3'd5,
    CFG_COEF_ROW_4   = 3'd6
  } cfg_idx_t;

  // coef_set_t[row][col] is one signed byte
  typedef logic [WIN-1:0][WIN-1:0][COEF_W-1:0] coef_set_t;

  // line store word: oldest line in the top byte
  localparam int LINE_WORD_W = (WIN - 1) * PIX_W;

  // one column of the window plus classification from the front end
  typedef struct packed {
    logic [WIN-1:0][PIX_W-1:0] col;   // col[i] goes to window row i
    logic                      emit;  // centre is interior
    logic                      first; // first interior centre of frame
    logic                      last;  // last interior centre of frame
  } col_item_t;

  localparam int Q_DEPTH = 4;

  // datapath widths
  localparam int PROD_W = 16;
  localparam int ROW_W  = 19;
  localparam int ACC_W  = 21;
  localparam int MAG_W  = 20;

  // /25 for magnitudes below 256*25: floor(m*5243 >> 17) is exact there
  localparam int SAT_LIMIT  = 6400;
  localparam int DIV_IN_W   = 13;
  localparam int DIV_RECIP  = 5243;
  localparam int DIV_SHIFT  = 17;
  localparam int DIV_PROD_W = 26;

  localparam int SUM_W = 32;

endpackage
`default_nettype wire

>>> rtl/cv5_queue.sv
`default_nettype none
module cv5_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cv5_pkg::col_item_t push_item,
  output logic                   full,
  input  wire logic              pop,
  output cv5_pkg::col_item_t     pop_item,
  output logic                   empty
);

  localparam int PW = $clog2(cv5_pkg::Q_DEPTH);
  localparam int CW = $clog2(cv5_pkg::Q_DEPTH + 1);

  cv5_pkg::col_item_t slot_r [cv5_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(cv5_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(cv5_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(cv5_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cv5_front.sv
`default_nettype none
module cv5_front #(
  parameter int MAX_WIDTH  = cv5_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cv5_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [cv5_pkg::PIX_W-1:0]      in_pixel,
  input  wire logic [cv5_pkg::CFG_SIZE_W-1:0] frame_width,
  input  wire logic [cv5_pkg::CFG_SIZE_W-1:0] frame_height,
  output logic                                q_push,
  output cv5_pkg::col_item_t                  q_item,
  input  wire logic                           q_full
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int SW = cv5_pkg::SIZE_W;
  localparam int LW = cv5_pkg::LINE_WORD_W;
  localparam int PW = cv5_pkg::PIX_W;

  logic [LW-1:0] line_mem [MAX_WIDTH];

  logic [AW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [SW-1:0] w_eff, h_eff, fw_x, fh_x, col_inc, row_inc;

  // stage holding the memory read
  logic          hold_valid_r;
  logic [LW-1:0] rd_word_r;
  logic [PW-1:0] pix_r;
  logic [AW-1:0] addr_r;
  logic          emit_r, first_r, last_r;
  logic          accept;
  logic          emit_c, first_c, last_c;

  assign fw_x  = SW'(frame_width);
  assign fh_x  = SW'(frame_height);
  assign w_eff = (fw_x < SW'(cv5_pkg::MIN_SIZE)) ? SW'(cv5_pkg::MIN_SIZE) :
                 (fw_x > SW'(MAX_WIDTH))        ? SW'(MAX_WIDTH) : fw_x;
  assign h_eff = (fh_x < SW'(cv5_pkg::MIN_SIZE)) ? SW'(cv5_pkg::MIN_SIZE) :
                 (fh_x > SW'(MAX_HEIGHT))       ? SW'(MAX_HEIGHT) : fh_x;

  assign q_push   = hold_valid_r && !q_full;
  assign in_ready = !hold_valid_r || !q_full;
  assign accept   = in_valid && in_ready;

  // classify the centre two lines up and two columns back
  assign emit_c  = (row_r >= HW'(cv5_pkg::WIN - 1)) && (col_r >= AW'(cv5_pkg::WIN - 1));
  assign first_c = (row_r == HW'(cv5_pkg::WIN - 1)) && (col_r == AW'(cv5_pkg::WIN - 1));
  assign last_c  = (SW'(row_r) == h_eff - 1'b1) && (SW'(col_r) == w_eff - 1'b1);

  assign col_inc = SW'(col_r) + 1'b1;
  assign row_inc = SW'(row_r) + 1'b1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : HW'(row_inc);
      end else begin
        col_nxt = AW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      hold_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) begin
        hold_valid_r <= 1'b1;
      end else if (q_push) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

  // line store: read on accept, write back shifted word when the column leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word_r <= line_mem[col_r];
      pix_r     <= in_pixel;
      addr_r    <= col_r;
      emit_r    <= emit_c;
      first_r   <= first_c;
      last_r    <= last_c;
    end
    if (q_push) begin
      line_mem[addr_r] <= {rd_word_r[LW-PW-1:0], pix_r};
    end
  end

  always_comb begin
    q_item.col[0] = rd_word_r[4*PW-1:3*PW];
    q_item.col[1] = rd_word_r[3*PW-1:2*PW];
    q_item.col[2] = rd_word_r[2*PW-1:PW];
    q_item.col[3] = rd_word_r[PW-1:0];
    q_item.col[4] = pix_r;
    q_item.emit   = emit_r;
    q_item.first  = first_r;
    q_item.last   = last_r;
  end

endmodule
`default_nettype wire

>>> rtl/cv5_back.sv
`default_nettype none
module cv5_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cv5_pkg::coef_set_t coef,
  input  wire cv5_pkg::col_item_t q_item,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [cv5_pkg::PIX_W-1:0] out_pixel,
  output logic [cv5_pkg::SUM_W-1:0] out_sum,
  output logic                    out_last
);

  localparam int N  = cv5_pkg::WIN;
  localparam int PW = cv5_pkg::PIX_W;

  logic [N-1:0][N-1:0][PW-1:0] win_r;

  logic                             s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic                             s0_first_r, s1_first_r, s2_first_r, s3_first_r, s4_first_r;
  logic                             s0_last_r, s1_last_r, s2_last_r, s3_last_r, s4_last_r;
  logic signed [cv5_pkg::PROD_W-1:0] prod_r [N][N];
  logic signed [cv5_pkg::PROD_W-1:0] prod_nxt [N][N];
  logic signed [cv5_pkg::ROW_W-1:0]  row_sum_r [N];
  logic signed [cv5_pkg::ROW_W-1:0]  row_sum_nxt [N];
  logic signed [cv5_pkg::ACC_W-1:0]  total;
  logic [cv5_pkg::MAG_W-1:0]         mag_r, mag_nxt;
  logic [cv5_pkg::DIV_PROD_W-1:0]    div_prod;
  logic [PW-1:0]                     quo_r, quo_nxt;
  logic [PW-1:0]                     out_pixel_r;
  logic [cv5_pkg::SUM_W-1:0]         out_sum_r;
  logic                              out_last_r;
  logic                              adv;

  // whole pipe moves together whenever the output register can take a word
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        prod_nxt[i][j] = cv5_pkg::PROD_W'($signed(coef[i][j]))
                       * cv5_pkg::PROD_W'($signed({1'b0, win_r[i][j]}));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      row_sum_nxt[i] = '0;
      for (int j = 0; j < N; j++) begin
        row_sum_nxt[i] = row_sum_nxt[i] + cv5_pkg::ROW_W'(prod_r[i][j]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < N; i++) begin
      total = total + cv5_pkg::ACC_W'(row_sum_r[i]);
    end
    mag_nxt = total[cv5_pkg::ACC_W-1] ? cv5_pkg::MAG_W'(-total) : cv5_pkg::MAG_W'(total);
  end

  // divide by 25 through a reciprocal, saturating above 255
  assign div_prod = cv5_pkg::DIV_PROD_W'(mag_r[cv5_pkg::DIV_IN_W-1:0])
                  * cv5_pkg::DIV_PROD_W'(cv5_pkg::DIV_RECIP);
  assign quo_nxt  = (mag_r >= cv5_pkg::MAG_W'(cv5_pkg::SAT_LIMIT)) ? '1
                  : div_prod[cv5_pkg::DIV_SHIFT +: PW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_sum_r   <= '0;
    end else if (adv) begin
      s0_v_r      <= q_pop && q_item.emit;
      s1_v_r      <= s0_v_r;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
      if (s4_v_r) begin
        out_sum_r <= (s4_first_r ? '0 : out_sum_r) + cv5_pkg::SUM_W'(quo_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_pop) begin
        for (int i = 0; i < N; i++) begin
          for (int j = 0; j < N - 1; j++) begin
            win_r[i][j] <= win_r[i][j+1];
          end
          win_r[i][N-1] <= q_item.col[i];
        end
      end
      s0_first_r <= q_item.first;
      s0_last_r  <= q_item.last;
      s1_first_r <= s0_first_r;
      s1_last_r  <= s0_last_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s3_first_r <= s2_first_r;
      s3_last_r  <= s2_last_r;
      s4_first_r <= s3_first_r;
      s4_last_r  <= s3_last_r;
      prod_r     <= prod_nxt;
      row_sum_r  <= row_sum_nxt;
      mag_r      <= mag_nxt;
      quo_r      <= quo_nxt;
      if (s4_v_r) begin
        out_pixel_r <= quo_r;
        out_last_r  <= s4_last_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_sum   = out_sum_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

>>> rtl/convolution_5x5_abs_scaled.sv
`default_nettype none
// 5x5 convolution of an 8-bit gray raster stream with |sum|/25 output, saturated
// to 255. Pixels arrive one word per clock in raster order while in_tready is
// high; only centres at least two pixels from every edge give a result, carrying
// the pixel, the running sum of this frame's results and tlast on the last
// interior centre. The block takes one pixel per clock sustained while the output
// is not stalled: the line store is one memory of MAX_WIDTH words, each holding a
// column of the four previous lines, read once and written once per pixel, and
// the 25 products go through a five-stage pipeline. A short queue sits between
// the line store front end and the arithmetic back end so that each side can
// stall on its own. The line store needs no clearing after reset: every result
// only uses pixels of the current frame. Frame sizes from the registers are
// clamped to 5..MAX_WIDTH and 5..MAX_HEIGHT; write registers only while the
// block is idle.
module convolution_5x5_abs_scaled #(
  parameter int MAX_WIDTH  = cv5_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cv5_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input pixels
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] pixel_in
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] filtered_pixel, [39:8] frame_sum
  output logic             out_tlast,  // last_of_frame
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [cv5_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cv5_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [cv5_pkg::CFG_SIZE_W-1:0] frame_width_r, frame_height_r;
  cv5_pkg::coef_set_t              coef_r;

  cv5_pkg::col_item_t q_in_item, q_out_item;
  logic               q_push, q_full, q_pop, q_empty;

  logic [cv5_pkg::PIX_W-1:0] res_pixel;
  logic [cv5_pkg::SUM_W-1:0] res_sum;

  // register file: always ready, out-of-range index ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= cv5_pkg::RST_FRAME_WIDTH;
      frame_height_r <= cv5_pkg::RST_FRAME_HEIGHT;
      for (int i = 0; i < cv5_pkg::WIN; i++) begin
        coef_r[i] <= cv5_pkg::RST_COEF_ROW;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        cv5_pkg::CFG_FRAME_WIDTH: begin
          frame_width_r <= cfg_data[cv5_pkg::CFG_SIZE_W-1:0];
        end
        cv5_pkg::CFG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_data[cv5_pkg::CFG_SIZE_W-1:0];
        end
        [cv5_pkg::CFG_COEF_ROW_0:cv5_pkg::CFG_COEF_ROW_4]: begin
          coef_r[cv5_pkg::CFG_INDEX_W'(cfg_index - cv5_pkg::CFG_COEF_ROW_0)] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // front end: position counters, line store, window column build
  cv5_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_pixel     (in_tdata),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_push       (q_push),
    .q_item       (q_in_item),
    .q_full       (q_full)
  );

  cv5_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty)
  );

  // back end: window, multiply-accumulate, abs, /25, running sum, output register
  cv5_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .q_item    (q_out_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (res_pixel),
    .out_sum   (res_sum),
    .out_last  (out_tlast)
  );

  assign out_tdata = {res_sum, res_pixel};

endmodule
`default_nettype wire

>>> rtl/cv5_checker.sv
`default_nettype none
module cv5_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast
);

  logic out_hs;
  logic frame_start_r;

  assign out_hs = out_tvalid && out_tready;

  // next result word opens a frame: after reset or after a tlast word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_start_r <= 1'b1;
    end else if (out_hs) begin
      frame_start_r <= out_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_frame_sum_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_hs && frame_start_r |-> out_tdata[39:8] == {24'd0, out_tdata[7:0]})
    else $error("frame sum not restarted on first word of frame");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind convolution_5x5_abs_scaled cv5_checker u_cv5_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
